FILE: design/button_debounce_repeat_defines.svh
// Assertion macros used by the port-level checker (bdr_checker) of the button debouncer.
// Depends on nothing; every macro samples on clock and is disabled by reset.
`ifndef BUTTON_DEBOUNCE_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_REPEAT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bdr_pkg.sv
// Shared types, codes and reset values of the button debouncer.
// Depends on nothing; every module of the block imports it.
package bdr_pkg;

   localparam int NumButtons = 8;
   localparam int FieldWidth = 8;
   localparam int CsrIndexWidth = 2;

   typedef logic [FieldWidth-1:0] field_type;
   typedef logic [NumButtons-1:0] btn_type;

   typedef enum logic [2:0] {
      ModeTick   = 3'd0,
      ModePress  = 3'd1,
      ModeRepeat = 3'd2,
      ModeShort  = 3'd3,
      ModeLong   = 3'd4,
      ModeDown   = 3'd5
   } mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrRepeatMask  = 2'd0,
      CsrRepeatStart = 2'd1,
      CsrRepeatNext  = 2'd2
   } csr_index_type;

   localparam field_type RepeatMaskReset  = 8'hff;
   localparam field_type RepeatStartReset = 8'd50;
   localparam field_type RepeatNextReset  = 8'd20;

   typedef struct packed {
      logic     accept;
      mode_type mode;
      logic     rep_event;
   } lane_ctrl_type;

   typedef struct packed {
      logic deb_next;
      logic press_next;
      logic answer;
   } lane_result_type;

   typedef struct packed {
      logic     accept;
      mode_type mode;
      logic     long_hit;
      btn_type  deb_next;
      btn_type  press_next;
   } rep_ctrl_type;

endpackage

FILE: design/bdr_lane.sv
// One button lane: two-bit vertical counter, debounced bit and event latches.
// Depends on bdr_pkg; the repeat event comes from bdr_repeat.
module bdr_lane import bdr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lane_ctrl_type   ctrl,
   input  logic            pin,
   input  logic            query,
   input  logic            rep_mask,
   output lane_result_type result
);

   logic deb_ff, deb_in;
   logic cl_ff, cl_in;
   logic ch_ff, ch_in;
   logic press_ff, press_in;
   logic rep_ff, rep_in;
   logic diff, cl_new, ch_new, flip;
   logic answer, rep_take;

   always_comb begin
      diff     = deb_ff ^ ~pin;
      cl_new   = ~(cl_ff & diff);
      ch_new   = cl_new ^ (ch_ff & diff);
      flip     = diff & cl_new & ch_new;
      deb_in   = deb_ff;
      cl_in    = cl_ff;
      ch_in    = ch_ff;
      press_in = press_ff;
      answer   = 1'b0;
      rep_take = 1'b0;
      case (ctrl.mode)
         ModeTick: begin
            deb_in   = deb_ff ^ flip;
            cl_in    = cl_new;
            ch_in    = ch_new;
            press_in = press_ff | (deb_in & flip);
         end
         ModePress: begin
            answer   = query & press_ff;
            press_in = press_ff & ~answer;
         end
         ModeRepeat: begin
            answer = query & rep_ff;
         end
         ModeShort: begin
            answer   = query & ~deb_ff & press_ff;
            press_in = press_ff & ~answer;
         end
         ModeLong: begin
            rep_take = query & rep_ff;
            answer   = rep_take & press_ff;
            press_in = press_ff & ~answer;
         end
         ModeDown: begin
            answer = deb_ff & query;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rep_in = rep_ff;
      case (ctrl.mode)
         ModeTick:   rep_in = rep_ff | (ctrl.rep_event & deb_in & rep_mask);
         ModeRepeat: rep_in = rep_ff & ~answer;
         ModeLong:   rep_in = rep_ff & ~rep_take;
         default:    rep_in = rep_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff   <= 1'b0;
         cl_ff    <= 1'b0;
         ch_ff    <= 1'b0;
         press_ff <= 1'b0;
         rep_ff   <= 1'b0;
      end else if (ctrl.accept) begin
         deb_ff   <= deb_in;
         cl_ff    <= cl_in;
         ch_ff    <= ch_in;
         press_ff <= press_in;
         rep_ff   <= rep_in;
      end
   end

   assign result.deb_next   = deb_in;
   assign result.press_next = press_in;
   assign result.answer     = answer;

endmodule

FILE: design/bdr_repeat.sv
// Shared repeat counter that merges the lanes' debounced and press state.
// Depends on bdr_pkg; drives the repeat event back into every bdr_lane.
module bdr_repeat import bdr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rep_ctrl_type ctrl,
   input  btn_type      rep_mask,
   input  field_type    start_ticks,
   input  field_type    next_ticks,
   output logic         rep_event
);

   field_type cnt_ff, cnt_in;
   field_type dec;
   logic      any_press, any_down;

   always_comb begin
      any_press = |(ctrl.press_next & rep_mask);
      any_down  = |(ctrl.deb_next & rep_mask);
      dec       = cnt_ff - field_type'(1);
      cnt_in    = cnt_ff;
      rep_event = 1'b0;
      if (ctrl.mode == ModeTick) begin
         if (cnt_ff == '0) begin
            if (any_press) begin
               cnt_in = (&start_ticks) ? start_ticks : start_ticks + field_type'(1);
            end
         end else if (!any_down) begin
            cnt_in = '0;
         end else if (dec == field_type'(1)) begin
            cnt_in    = next_ticks;
            rep_event = 1'b1;
         end else begin
            cnt_in = dec;
         end
      end else if (ctrl.mode == ModeLong && ctrl.long_hit) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctrl.accept) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: design/button_debounce_repeat.sv
// Channel  | Direction | Beat contents
// req      | in        | mode, raw_pins, query_mask
// rsp      | out       | answer_bits, debounced_now
// csr      | in        | write_enable, index, write_data (no read-back)
//
// The lanes and the repeat counter compute each beat combinationally, and the result
// lands in a single output register in the cycle after the input beat is taken.
// A new input beat is taken whenever the output register is empty or being drained.
// Synchronous active-high reset clears all button state and loads register defaults.
// A stalled result holds the input side only while rsp_ready stays low.
module button_debounce_repeat import bdr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_mode,
   input  field_type                req_raw_pins,
   input  field_type                req_query_mask,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output field_type                rsp_answer_bits,
   output field_type                rsp_debounced_now,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  field_type                csr_write_data
);

   field_type       rep_mask_ff, start_ff, next_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   field_type       answer_ff, debounced_ff;
   logic            accept;
   logic            rep_event;
   mode_type        mode;
   btn_type         answer_vec, deb_vec, press_vec, rm_vec;
   lane_ctrl_type   lane_ctrl;
   lane_result_type lane_res [NumButtons];
   rep_ctrl_type    rep_ctrl;

   assign mode      = mode_type'(req_mode);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rm_vec    = rep_mask_ff[NumButtons-1:0];

   assign lane_ctrl.accept    = accept;
   assign lane_ctrl.mode      = mode;
   assign lane_ctrl.rep_event = rep_event;

   for (genvar g = 0; g < NumButtons; g++) begin : g_lane
      bdr_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .pin      (req_raw_pins[g]),
         .query    (req_query_mask[g]),
         .rep_mask (rm_vec[g]),
         .result   (lane_res[g])
      );
      assign answer_vec[g] = lane_res[g].answer;
      assign deb_vec[g]    = lane_res[g].deb_next;
      assign press_vec[g]  = lane_res[g].press_next;
   end

   assign rep_ctrl.accept     = accept;
   assign rep_ctrl.mode       = mode;
   assign rep_ctrl.long_hit   = |answer_vec;
   assign rep_ctrl.deb_next   = deb_vec;
   assign rep_ctrl.press_next = press_vec;

   bdr_repeat u_repeat (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (rep_ctrl),
      .rep_mask    (rm_vec),
      .start_ticks (start_ff),
      .next_ticks  (next_ff),
      .rep_event   (rep_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_mask_ff <= RepeatMaskReset;
         start_ff    <= RepeatStartReset;
         next_ff     <= RepeatNextReset;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CsrRepeatMask:  rep_mask_ff <= csr_write_data;
            CsrRepeatStart: start_ff    <= csr_write_data;
            CsrRepeatNext:  next_ff     <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         answer_ff    <= field_type'(answer_vec);
         debounced_ff <= field_type'(deb_vec);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_answer_bits   = answer_ff;
   assign rsp_debounced_now = debounced_ff;

endmodule

FILE: design/bdr_checker.sv
// Port-level checks of the button debouncer, bound to the top level.
// Depends on bdr_pkg and the assertion macros in button_debounce_repeat_defines.svh.
`include "button_debounce_repeat_defines.svh"

module bdr_checker import bdr_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic [2:0] req_mode,
   input field_type req_query_mask,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input field_type rsp_answer_bits,
   input field_type rsp_debounced_now
);

   logic req_beat;

   assign req_beat = req_valid && req_ready;

   `BDR_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "input stalled with empty output")
   `BDR_ASSERT_NEXT(a_tick_no_answer, req_beat && req_mode == ModeTick, rsp_valid && rsp_answer_bits == '0, "tick beat gave a nonzero answer")
   `BDR_ASSERT_NEXT(a_answer_in_mask, req_beat, rsp_valid && (rsp_answer_bits & ~$past(req_query_mask)) == '0, "answer outside the query mask")
   `BDR_ASSERT_NEXT(a_down_answer, req_beat && req_mode == ModeDown, rsp_answer_bits == (rsp_debounced_now & $past(req_query_mask)), "down query disagrees with debounced state")
   `BDR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_answer_bits), "stalled result beat changed")

endmodule

bind button_debounce_repeat bdr_checker u_bdr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_mode          (req_mode),
   .req_query_mask    (req_query_mask),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_answer_bits   (rsp_answer_bits),
   .rsp_debounced_now (rsp_debounced_now)
);

FILE: bench/button_debounce_repeat_checker.sv
// Checker for the button debouncer: predicts every response beat from request and register
// traffic, then compares it field by field with what the block returns.
// Depends on bdr_pkg for field types, mode codes, register indexes and reset values.
`timescale 1ns / 1ps

module button_debounce_repeat_checker import bdr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [2:0]               req_mode,
   input  field_type                req_raw_pins,
   input  field_type                req_query_mask,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  field_type                rsp_answer_bits,
   input  field_type                rsp_debounced_now,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  field_type                csr_write_data,
   output int                       error_count,
   output int                       beats_in,
   output int                       beats_out
);

   typedef struct packed {
      field_type answer;
      field_type held;
   } key_status_type;

   localparam int PrintLimit = 40;

   key_status_type status_queue[$];
   int             error_total = 0;

   field_type cfg_mask, cfg_start, cfg_next;
   field_type deb_state, vc_low, vc_high, press_flags, repeat_flags, repeat_timer;

   assign error_count = error_total;

   task automatic report_failure(input string msg);
      if (error_total < PrintLimit) begin
         $display("checker: result %0d: %s", beats_out, msg);
      end
      error_total++;
   endtask

   function automatic field_type claim_press(input field_type sel);
      field_type hit;
      hit = sel & press_flags;
      press_flags = press_flags ^ hit;
      return hit;
   endfunction

   function automatic field_type claim_repeat(input field_type sel);
      field_type hit;
      hit = sel & repeat_flags;
      repeat_flags = repeat_flags ^ hit;
      return hit;
   endfunction

   task automatic sample_pins(input field_type pins);
      field_type moved;
      moved = deb_state ^ ~pins;
      vc_low = ~(vc_low & moved);
      vc_high = vc_low ^ (vc_high & moved);
      moved = moved & vc_low & vc_high;
      deb_state = deb_state ^ moved;
      press_flags = press_flags | (deb_state & moved);
      if (repeat_timer == 8'd0) begin
         if ((press_flags & cfg_mask) != 8'd0) begin
            repeat_timer = (cfg_start == 8'hff) ? 8'hff : cfg_start + 8'd1;
         end
      end else if ((deb_state & cfg_mask) == 8'd0) begin
         repeat_timer = 8'd0;
      end else begin
         repeat_timer = repeat_timer - 8'd1;
         if (repeat_timer == 8'd1) begin
            repeat_timer = cfg_next;
            repeat_flags = repeat_flags | (deb_state & cfg_mask);
         end
      end
   endtask

   task automatic step_keys(input logic [2:0] mode, input field_type pins,
                            input field_type sel, output field_type answer);
      answer = 8'd0;
      case (mode)
         ModeTick: begin
            sample_pins(pins);
         end
         ModePress: begin
            answer = claim_press(sel);
         end
         ModeRepeat: begin
            answer = claim_repeat(sel);
         end
         ModeShort: begin
            answer = claim_press(sel & ~deb_state);
         end
         ModeLong: begin
            answer = claim_press(claim_repeat(sel));
            if (answer != 8'd0) begin
               repeat_timer = 8'd0;
            end
         end
         ModeDown: begin
            answer = deb_state & sel;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      key_status_type wanted;
      field_type      answer;
      if (reset) begin
         cfg_mask = RepeatMaskReset;
         cfg_start = RepeatStartReset;
         cfg_next = RepeatNextReset;
         deb_state = 8'd0;
         vc_low = 8'd0;
         vc_high = 8'd0;
         press_flags = 8'd0;
         repeat_flags = 8'd0;
         repeat_timer = 8'd0;
         status_queue.delete();
         beats_in <= 0;
         beats_out <= 0;
      end else begin
         if (req_valid && req_ready) begin
            step_keys(req_mode, req_raw_pins, req_query_mask, answer);
            status_queue.push_back('{answer: answer, held: deb_state});
            beats_in <= beats_in + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (status_queue.size() == 0) begin
               report_failure($sformatf("unexpected beat, answer %02h debounced %02h",
                                        rsp_answer_bits, rsp_debounced_now));
            end else begin
               wanted = status_queue.pop_front();
               if (rsp_answer_bits !== wanted.answer) begin
                  report_failure($sformatf("answer_bits %02h, expected %02h",
                                           rsp_answer_bits, wanted.answer));
               end
               if (rsp_debounced_now !== wanted.held) begin
                  report_failure($sformatf("debounced_now %02h, expected %02h",
                                           rsp_debounced_now, wanted.held));
               end
            end
            beats_out <= beats_out + 1;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CsrRepeatMask: begin
                  cfg_mask = csr_write_data;
               end
               CsrRepeatStart: begin
                  cfg_start = csr_write_data;
               end
               CsrRepeatNext: begin
                  cfg_next = csr_write_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

FILE: bench/button_debounce_repeat_tb.sv
// Top of the button debouncer bench: clock, reset, stimulus, handshake idling and verdict.
// Depends on bdr_pkg, the button_debounce_repeat block and button_debounce_repeat_checker.
`timescale 1ns / 1ps

module button_debounce_repeat_tb;
   import bdr_pkg::*;

   localparam logic [2:0] ModeSpareLow = 3'd6;
   localparam logic [2:0] ModeSpareHigh = 3'd7;
   localparam int WatchdogLimit = 2000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_mode = ModeTick;
   field_type                req_raw_pins = 8'hff;
   field_type                req_query_mask = 8'h00;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   field_type                rsp_answer_bits;
   field_type                rsp_debounced_now;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CsrRepeatMask;
   field_type                csr_write_data = 8'h00;

   int        error_count, beats_in, beats_out;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        idle_cycles = 0;
   int        sent_beats = 0;
   int        settings_written = 0;
   field_type pins_now = 8'hff;

   button_debounce_repeat u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_raw_pins      (req_raw_pins),
      .req_query_mask    (req_query_mask),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_answer_bits   (rsp_answer_bits),
      .rsp_debounced_now (rsp_debounced_now),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   button_debounce_repeat_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_raw_pins      (req_raw_pins),
      .req_query_mask    (req_query_mask),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_answer_bits   (rsp_answer_bits),
      .rsp_debounced_now (rsp_debounced_now),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .error_count       (error_count),
      .beats_in          (beats_in),
      .beats_out         (beats_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_beat(input logic [2:0] mode, input field_type pins,
                            input field_type sel);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_raw_pins <= pins;
      req_query_mask <= sel;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sent_beats++;
   endtask

   task automatic send_query();
      logic [2:0] mode;
      field_type  sel;
      case ($urandom_range(0, 4))
         0: mode = ModePress;
         1: mode = ModeRepeat;
         2: mode = ModeShort;
         3: mode = ModeLong;
         default: mode = ModeDown;
      endcase
      if ($urandom_range(0, 29) == 0) begin
         mode = ($urandom_range(0, 1) != 0) ? ModeSpareLow : ModeSpareHigh;
      end
      sel = ($urandom_range(0, 1) != 0) ? 8'hff : field_type'($urandom);
      send_beat(mode, field_type'($urandom), sel);
   endtask

   task automatic hold_pins(input field_type pins, input int ticks, input int query_pct);
      repeat (ticks) begin
         if ($urandom_range(0, 99) < query_pct) begin
            send_query();
         end
         send_beat(ModeTick, pins, field_type'($urandom));
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_in - beats_out > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
         end
         1: begin
            send_idle_pct = 48;
            recv_stall_pct <= 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct <= 48;
         end
         default: begin
            send_idle_pct = 31;
            recv_stall_pct <= 31;
         end
      endcase
   endtask

   task automatic apply_setting(input int phase, input field_type mask,
                                input field_type start, input field_type next_ticks);
      drain_results();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CsrRepeatMask;
      csr_write_data <= mask;
      @(posedge clock);
      csr_index <= CsrRepeatStart;
      csr_write_data <= start;
      @(posedge clock);
      csr_index <= CsrRepeatNext;
      csr_write_data <= next_ticks;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      set_idling(phase);
      settings_written++;
   endtask

   task automatic run_random(input int beats, input int hold_max);
      int goal;
      int kind;
      goal = sent_beats + beats;
      while (sent_beats < goal) begin
         kind = $urandom_range(0, 29);
         if (kind == 0) begin
            drain_results();
         end else if (kind < 19) begin
            if ($urandom_range(0, 3) == 0) begin
               pins_now = field_type'($urandom);
            end else begin
               pins_now = pins_now ^ field_type'($urandom & $urandom);
            end
            hold_pins(pins_now, ($urandom_range(0, 2) == 0) ? $urandom_range(4, hold_max)
                                                           : $urandom_range(1, 6), 25);
         end else if (kind < 25) begin
            repeat ($urandom_range(1, 5)) begin
               send_beat(ModeTick, field_type'($urandom), field_type'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_query();
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(ModeTick, 8'hff, 8'h00);
      send_beat(ModePress, 8'hff, 8'hff);
      send_beat(ModeRepeat, 8'hff, 8'hff);
      send_beat(ModeShort, 8'hff, 8'hff);
      send_beat(ModeLong, 8'hff, 8'hff);
      send_beat(ModeDown, 8'hff, 8'hff);
      hold_pins(8'h00, 4, 0);
      send_beat(ModeDown, 8'hff, 8'h00);
      send_beat(ModeShort, 8'h00, 8'hff);
      send_beat(ModePress, 8'h00, 8'h0f);
      send_beat(ModeLong, 8'h00, 8'hff);
      send_beat(ModeSpareLow, 8'h5a, 8'hff);
      send_beat(ModeSpareHigh, 8'ha5, 8'hff);
      hold_pins(8'hff, 4, 0);
      send_beat(ModeShort, 8'hff, 8'hff);
      send_beat(ModePress, 8'hff, 8'hff);
      send_beat(ModeTick, 8'h55, 8'hff);
      send_beat(ModeTick, 8'hff, 8'h00);

      apply_setting(0, 8'hff, 8'd2, 8'd2);
      run_random(80, 20);
      apply_setting(1, field_type'($urandom), 8'd254, 8'd255);
      run_random(80, 40);
      apply_setting(2, field_type'($urandom), field_type'($urandom_range(2, 6)), 8'd0);
      run_random(80, 20);
      apply_setting(3, field_type'($urandom), 8'd3, 8'd1);
      run_random(80, 20);

      // A start delay of 255 must saturate rather than wrap, so hold one button long enough.
      apply_setting(4, 8'hff, 8'd255, 8'd3);
      pins_now = 8'hfe;
      hold_pins(pins_now, 270, 0);
      send_beat(ModeRepeat, 8'hfe, 8'hff);
      hold_pins(pins_now, 8, 0);
      send_beat(ModeLong, 8'hfe, 8'hff);
      run_random(40, 20);

      apply_setting(5, 8'h00, field_type'($urandom_range(2, 12)),
                    field_type'($urandom_range(2, 12)));
      run_random(80, 40);

      drain_results();
      repeat (10) @(posedge clock);

      $display("Run covered %0d request beats and %0d result beats over %0d register settings,",
               beats_in, beats_out, settings_written);
      $display("with bounce noise, long holds, repeat reloads and four idling patterns.");
      if (error_count == 0 && beats_in == beats_out) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
